>>> design/cti_pkg.sv
package cti_pkg;

   localparam int TableDepthDefault = 4096;

   localparam int ReqDataW = 144;
   localparam int RspDataW = 104;
   localparam int CsrIdxW  = 2;
   localparam int CsrDataW = 48;

   localparam logic [CsrIdxW-1:0] CSR_TABLE_COUNT = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_TEMP_SCALE  = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_COOL_SCALE  = 2'd2;
   localparam logic [CsrIdxW-1:0] CSR_FLOOR_TEMP  = 2'd3;

   localparam logic [12:0] COUNT_RESET = 13'd2;
   localparam logic [47:0] TSCALE_RESET = 48'd65536;
   localparam logic [31:0] CSCALE_RESET = 32'd0;
   localparam logic [31:0] FLOOR_RESET = 32'd10000;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_CELL = 1'b1;

   localparam logic [6:0] DIV_STEPS_TEMP = 7'd32;
   localparam logic [6:0] DIV_STEPS_RATE = 7'd64;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_DRAIN,
      ST_POST,
      ST_TDIV,
      ST_SRCH,
      ST_SCMP,
      ST_FLO,
      ST_FHI,
      ST_FGOT,
      ST_DIFF,
      ST_MDIV,
      ST_SCALE,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      PH_NUM,
      PH_DIFF,
      PH_SQ,
      PH_F,
      PH_PROD
   } phase_type;

   typedef struct packed {
      logic        start;
      logic [6:0]  steps;
      logic [31:0] divisor;
      logic [31:0] rem;
      logic [63:0] quo;
   } div_cmd_type;

endpackage

>>> design/cti_ram.sv
module cti_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

>>> design/cti_divider.sv
module cti_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  cti_pkg::div_cmd_type cmd,
   output logic                 busy,
   output logic [63:0]          quotient
);
   import cti_pkg::*;

   logic [6:0]  cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] div_ff, div_in;
   logic [63:0] quo_ff, quo_in;
   logic [32:0] trial;
   logic [32:0] diff;
   logic        ge;

   // restoring division, one quotient bit per cycle
   always_comb begin
      trial  = {rem_ff, quo_ff[63]};
      diff   = trial - {1'b0, div_ff};
      ge     = trial >= {1'b0, div_ff};
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      quo_in = quo_ff;
      if (cmd.start) begin
         cnt_in = cmd.steps;
         rem_in = cmd.rem;
         div_in = cmd.divisor;
         quo_in = cmd.quo;
      end else if (cnt_ff != 7'd0) begin
         cnt_in = cnt_ff - 7'd1;
         rem_in = ge ? diff[31:0] : trial[31:0];
         quo_in = {quo_ff[62:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 7'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

   assign busy     = cnt_ff != 7'd0;
   assign quotient = quo_ff;

endmodule

>>> design/cooling_table_interpolator_unit.sv
// channel | dir | handshake         | payload
// req     | in  | req_tvalid/tready | tuser mode; tdata index, table temp, table rate, p, rho
// rsp     | out | rsp_tvalid/tready | tdata temperature, cooling rate, below floor, zero density
// csr     | in  | csr_we            | csr_index, csr_wdata
// A cell transaction runs a binary search over the table (12 steps at 4096 entries)
// and up to two passes, of 32 and 64 steps, through the shared serial divider.
// One transaction at a time; a new one is taken while the last result waits in
// the output register. Reset is synchronous; table contents are not cleared.
module cooling_table_interpolator_unit #(
   parameter int TABLE_DEPTH = cti_pkg::TableDepthDefault
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // [11:0] entry_index, [43:12] entry_temperature, [75:44] entry_rate,
   // [107:76] pressure, [139:108] density
   input  logic [cti_pkg::ReqDataW-1:0] req_tdata,
   // [0] mode
   input  logic                         req_tuser,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // [31:0] temperature, [95:32] cooling_rate, [96] below_floor, [97] density_zero
   output logic [cti_pkg::RspDataW-1:0] rsp_tdata,
   input  logic                         csr_we,
   input  logic [cti_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [cti_pkg::CsrDataW-1:0] csr_wdata
);
   import cti_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);

   state_type   state_ff, state_in;
   phase_type   phase_ff, phase_in;

   logic [12:0] count_ff;
   logic [47:0] tscale_ff;
   logic [31:0] cscale_ff;
   logic [31:0] floor_ff;

   logic [11:0] f_idx;
   logic [31:0] f_etemp, f_erate, f_p, f_rho;
   logic [31:0] idx32, cnt32, n32, hi32;
   logic        idx_ok;

   logic [31:0] p_ff, rho_ff, temp_ff;
   logic [AW-1:0] lo_ff, hi_ff, mid_ff;
   logic [AW:0]   sum_w;
   logic [AW-1:0] mid_w;
   logic          span_gt1;
   logic [31:0] tlo_ff, llo_ff, thi_ff, lhi_ff;
   logic [31:0] magd_ff, magt_ff, magl_ff;
   logic        neg_ff;
   logic [63:0] m_ff, scrh_ff, d2_ff, cool_ff;
   logic [95:0] f_ff;
   logic        below_ff, dz_ff;

   logic [2:0]   ms_ff;
   logic [63:0]  prod_ff;
   logic [1:0]   off_ff, off_w;
   logic         accv_ff;
   logic [159:0] acc_ff, addend;
   logic [31:0]  mul_a, mul_b;
   logic [63:0]  mul_p;
   logic         mul_last, mul_begin;

   logic [63:0] num_w;
   logic        tsat_w;
   logic [32:0] dt_w, dtt_w, dl_w, ndt_w, ndtt_w, ndl_w;
   logic [31:0] magd_w, magt_w, magl_w;
   logic        any_zero;
   logic [64:0] psum_w;
   logic [63:0] llo64, scrh_w, cool_w;
   logic        below_w, rsp_free;

   logic              ram_we;
   logic [AW-1:0]     ram_addr;
   logic [63:0]       ram_rdata;
   div_cmd_type       div_cmd;
   logic              div_busy;
   logic [63:0]       div_q;

   logic              rsp_valid_ff;
   logic [RspDataW-1:0] rsp_data_ff;

   assign f_idx   = req_tdata[11:0];
   assign f_etemp = req_tdata[43:12];
   assign f_erate = req_tdata[75:44];
   assign f_p     = req_tdata[107:76];
   assign f_rho   = req_tdata[139:108];

   assign idx32  = 32'(f_idx);
   assign idx_ok = idx32 < 32'(TABLE_DEPTH);
   assign cnt32  = 32'(count_ff);
   assign n32    = (cnt32 < 32'd2) ? 32'd2 :
                   (cnt32 > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : cnt32;
   assign hi32   = n32 - 32'd1;

   assign sum_w    = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_w    = sum_w[AW:1];
   assign span_gt1 = (hi_ff - lo_ff) > AW'(1);

   // shared 32x32 multiplier operand selection
   always_comb begin
      mul_a = p_ff;
      mul_b = tscale_ff[31:0];
      off_w = 2'd0;
      mul_last = 1'b1;
      case (phase_ff)
         PH_NUM: begin
            mul_b    = (ms_ff == 3'd0) ? tscale_ff[31:0] : {16'd0, tscale_ff[47:32]};
            off_w    = ms_ff[1:0];
            mul_last = ms_ff == 3'd1;
         end
         PH_DIFF: begin
            mul_a = magl_ff;
            mul_b = magt_ff;
         end
         PH_SQ: begin
            mul_a = rho_ff;
            mul_b = rho_ff;
         end
         PH_F: begin
            mul_a    = cscale_ff;
            mul_b    = (ms_ff == 3'd0) ? d2_ff[31:0] : d2_ff[63:32];
            off_w    = ms_ff[1:0];
            mul_last = ms_ff == 3'd1;
         end
         PH_PROD: begin
            case (ms_ff[2:1])
               2'd0:    mul_a = f_ff[31:0];
               2'd1:    mul_a = f_ff[63:32];
               default: mul_a = f_ff[95:64];
            endcase
            mul_b    = ms_ff[0] ? scrh_ff[63:32] : scrh_ff[31:0];
            off_w    = ms_ff[2:1] + {1'b0, ms_ff[0]};
            mul_last = ms_ff == 3'd5;
         end
         default: begin
            mul_last = 1'b1;
         end
      endcase
   end

   assign mul_p  = {32'd0, mul_a} * {32'd0, mul_b};
   assign addend = {96'd0, prod_ff} << {off_ff, 5'd0};

   assign num_w  = acc_ff[79:16];
   assign tsat_w = (rho_ff == 32'd0) || (num_w[63:32] >= rho_ff);

   always_comb begin
      dt_w   = {1'b0, thi_ff} - {1'b0, tlo_ff};
      dtt_w  = {1'b0, temp_ff} - {1'b0, tlo_ff};
      dl_w   = {1'b0, lhi_ff} - {1'b0, llo_ff};
      ndt_w  = 33'd0 - dt_w;
      ndtt_w = 33'd0 - dtt_w;
      ndl_w  = 33'd0 - dl_w;
      magd_w = dt_w[32] ? ndt_w[31:0] : dt_w[31:0];
      magt_w = dtt_w[32] ? ndtt_w[31:0] : dtt_w[31:0];
      magl_w = dl_w[32] ? ndl_w[31:0] : dl_w[31:0];
      any_zero = (dt_w == 33'd0) || (dtt_w == 33'd0) || (dl_w == 33'd0);
   end

   always_comb begin
      llo64  = {32'd0, llo_ff};
      psum_w = {33'd0, llo_ff} + {1'b0, m_ff};
      if (!neg_ff) begin
         scrh_w = psum_w[64] ? {64{1'b1}} : psum_w[63:0];
      end else begin
         scrh_w = (m_ff >= llo64) ? 64'd0 : llo64 - m_ff;
      end
   end

   assign below_w = temp_ff < floor_ff;
   assign cool_w  = (acc_ff[159:127] != 33'd0) ? {1'b1, 63'd0} : 64'd0 - acc_ff[127:64];
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = (req_tuser == MODE_CELL) ? ST_MUL : ST_DONE;
            end
         end
         ST_MUL: begin
            if (mul_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_POST;
         ST_POST: begin
            case (phase_ff)
               PH_NUM:  state_in = tsat_w ? ST_SRCH : ST_TDIV;
               PH_DIFF: state_in = ST_MDIV;
               PH_SQ:   state_in = ST_MUL;
               PH_F:    state_in = ST_MUL;
               default: state_in = ST_DONE;
            endcase
         end
         ST_TDIV: begin
            if (!div_busy) begin
               state_in = ST_SRCH;
            end
         end
         ST_SRCH:  state_in = span_gt1 ? ST_SCMP : ST_FLO;
         ST_SCMP:  state_in = ST_SRCH;
         ST_FLO:   state_in = ST_FHI;
         ST_FHI:   state_in = ST_FGOT;
         ST_FGOT:  state_in = ST_DIFF;
         ST_DIFF:  state_in = any_zero ? ST_SCALE : ST_MUL;
         ST_MDIV: begin
            if (!div_busy) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: state_in = below_w ? ST_DONE : ST_MUL;
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready = 1'b0;
      ram_we     = 1'b0;
      ram_addr   = lo_ff;
      mul_begin  = 1'b0;
      phase_in   = phase_ff;
      div_cmd    = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            ram_addr   = idx32[AW-1:0];
            ram_we     = req_tvalid && (req_tuser == MODE_LOAD) && idx_ok;
            if (req_tvalid && (req_tuser == MODE_CELL)) begin
               mul_begin = 1'b1;
               phase_in  = PH_NUM;
            end
         end
         ST_POST: begin
            case (phase_ff)
               PH_NUM: begin
                  div_cmd.start   = !tsat_w;
                  div_cmd.steps   = DIV_STEPS_TEMP;
                  div_cmd.divisor = rho_ff;
                  div_cmd.rem     = num_w[63:32];
                  div_cmd.quo     = {num_w[31:0], 32'd0};
               end
               PH_DIFF: begin
                  div_cmd.start   = 1'b1;
                  div_cmd.steps   = DIV_STEPS_RATE;
                  div_cmd.divisor = magd_ff;
                  div_cmd.rem     = 32'd0;
                  div_cmd.quo     = acc_ff[63:0];
               end
               PH_SQ: begin
                  mul_begin = 1'b1;
                  phase_in  = PH_F;
               end
               PH_F: begin
                  mul_begin = 1'b1;
                  phase_in  = PH_PROD;
               end
               default: begin
                  mul_begin = 1'b0;
               end
            endcase
         end
         ST_SRCH: ram_addr = mid_w;
         ST_FLO:  ram_addr = lo_ff;
         ST_FHI:  ram_addr = hi_ff;
         ST_DIFF: begin
            if (!any_zero) begin
               mul_begin = 1'b1;
               phase_in  = PH_DIFF;
            end
         end
         ST_SCALE: begin
            if (!below_w) begin
               mul_begin = 1'b1;
               phase_in  = PH_SQ;
            end
         end
         default: begin
            ram_addr = lo_ff;
         end
      endcase
   end

   cti_ram #(
      .WIDTH (64),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata ({f_erate, f_etemp}),
      .rdata (ram_rdata)
   );

   cti_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .busy     (div_busy),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         accv_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= COUNT_RESET;
         tscale_ff    <= TSCALE_RESET;
         cscale_ff    <= CSCALE_RESET;
         floor_ff     <= FLOOR_RESET;
      end else begin
         state_ff <= state_in;
         accv_ff  <= state_ff == ST_MUL;
         if (state_ff == ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_TABLE_COUNT: count_ff  <= csr_wdata[12:0];
               CSR_TEMP_SCALE:  tscale_ff <= csr_wdata;
               CSR_COOL_SCALE:  cscale_ff <= csr_wdata[31:0];
               CSR_FLOOR_TEMP:  floor_ff  <= csr_wdata[31:0];
               default:         floor_ff  <= floor_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= mul_p;
      off_ff   <= off_w;
      phase_ff <= phase_in;
      if (mul_begin) begin
         ms_ff  <= 3'd0;
         acc_ff <= '0;
      end else begin
         if (state_ff == ST_MUL) begin
            ms_ff <= ms_ff + 3'd1;
         end
         if (accv_ff) begin
            acc_ff <= acc_ff + addend;
         end
      end
      case (state_ff)
         ST_IDLE: begin
            p_ff     <= f_p;
            rho_ff   <= f_rho;
            lo_ff    <= '0;
            hi_ff    <= hi32[AW-1:0];
            temp_ff  <= 32'd0;
            cool_ff  <= 64'd0;
            below_ff <= 1'b0;
            dz_ff    <= (req_tuser == MODE_CELL) && (f_rho == 32'd0);
         end
         ST_POST: begin
            case (phase_ff)
               PH_NUM: begin
                  if (tsat_w) begin
                     temp_ff <= 32'hFFFF_FFFF;
                  end
               end
               PH_SQ:   d2_ff   <= acc_ff[63:0];
               PH_F:    f_ff    <= acc_ff[95:0];
               PH_PROD: cool_ff <= cool_w;
               default: d2_ff   <= d2_ff;
            endcase
         end
         ST_TDIV: begin
            if (!div_busy) begin
               temp_ff <= div_q[31:0];
            end
         end
         ST_SRCH: mid_ff <= mid_w;
         ST_SCMP: begin
            if (temp_ff <= ram_rdata[31:0]) begin
               hi_ff <= mid_ff;
            end else begin
               lo_ff <= mid_ff;
            end
         end
         ST_FHI: begin
            tlo_ff <= ram_rdata[31:0];
            llo_ff <= ram_rdata[63:32];
         end
         ST_FGOT: begin
            thi_ff <= ram_rdata[31:0];
            lhi_ff <= ram_rdata[63:32];
         end
         ST_DIFF: begin
            magd_ff <= magd_w;
            magt_ff <= magt_w;
            magl_ff <= magl_w;
            neg_ff  <= !any_zero && (dt_w[32] ^ dtt_w[32] ^ dl_w[32]);
            m_ff    <= 64'd0;
         end
         ST_MDIV: begin
            if (!div_busy) begin
               m_ff <= div_q;
            end
         end
         ST_SCALE: begin
            scrh_ff  <= scrh_w;
            below_ff <= below_w;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_data_ff <= {6'd0, dz_ff, below_ff, cool_ff, temp_ff};
            end
         end
         default: begin
            mid_ff <= mid_ff;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_cool_nonpos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[95] || rsp_tdata[95:32] == 64'd0))
      else $error("positive cooling result");

   a_below_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[96]) |-> rsp_tdata[95:32] == 64'd0)
      else $error("cooling not zero below floor");

   a_dz_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[97]) |-> rsp_tdata[31:0] == 32'hFFFF_FFFF)
      else $error("zero density without saturated temperature");

   a_idle_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !div_busy)
      else $error("divider busy while idle");

endmodule

>>> dv/cooling_table_interpolator_unit_test.sv
module cooling_table_interpolator_unit_test;
   import cti_pkg::*;

   typedef struct {
      bit [31:0] temperature;
      bit [63:0] cooling_rate;
      bit        below_floor;
      bit        density_zero;
   } cooling_result_t;

   class cooling_scoreboard;
      bit [31:0]       table_temp [TableDepthDefault];
      bit [31:0]       table_rate [TableDepthDefault];
      bit [12:0]       entry_count = COUNT_RESET;
      bit [47:0]       temp_scale  = TSCALE_RESET;
      bit [31:0]       cool_scale  = CSCALE_RESET;
      bit [31:0]       floor_temp  = FLOOR_RESET;
      cooling_result_t pending_results[$];
      int              mismatches = 0;

      function void write_reg(bit [CsrIdxW-1:0] idx, bit [CsrDataW-1:0] val);
         case (idx)
            CSR_TABLE_COUNT: entry_count = val[12:0];
            CSR_TEMP_SCALE:  temp_scale  = val[47:0];
            CSR_COOL_SCALE:  cool_scale  = val[31:0];
            CSR_FLOOR_TEMP:  floor_temp  = val[31:0];
            default: ;
         endcase
      endfunction

      function bit [63:0] magnitude(longint v);
         return v < 0 ? 64'(-v) : 64'(v);
      endfunction

      function void note_request(bit mode, bit [ReqDataW-1:0] d);
         cooling_result_t r;
         bit [31:0]  p, rho;
         bit [63:0]  pv, pl, ph, num, q, m, scrh;
         bit [159:0] prodv, a, rv, sv;
         longint     tlo, thi, llo, lhi, dt, dtt, dl;
         int         n, lo, hi, mid;
         bit         neg;
         r = '{default: 0};
         if (mode == MODE_LOAD) begin
            table_temp[d[11:0]] = d[43:12];
            table_rate[d[11:0]] = d[75:44];
            pending_results.push_back(r);
            return;
         end
         p = d[107:76];
         rho = d[139:108];
         pv = p;
         pl = pv * 64'(temp_scale[31:0]);
         ph = pv * 64'(temp_scale[47:32]);
         num = (ph << 16) + (pl >> 16);
         r.density_zero = (rho == 0);
         if (rho == 0) begin
            r.temperature = '1;
         end else begin
            q = num / 64'(rho);
            r.temperature = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
         end
         n = entry_count;
         if (n < 2) n = 2;
         if (n > TableDepthDefault) n = TableDepthDefault;
         lo = 0;
         hi = n - 1;
         while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (r.temperature <= table_temp[mid]) hi = mid; else lo = mid;
         end
         tlo = table_temp[lo];
         thi = table_temp[hi];
         llo = table_rate[lo];
         lhi = table_rate[hi];
         dt = thi - tlo;
         dtt = longint'(r.temperature) - tlo;
         dl = lhi - llo;
         m = 0;
         neg = 0;
         if (dt != 0 && dtt != 0 && dl != 0) begin
            neg = (dt < 0) ^ (dtt < 0) ^ (dl < 0);
            m = (magnitude(dl) * magnitude(dtt)) / magnitude(dt);
         end
         if (!neg) begin
            scrh = 64'(llo) + m;
            if (scrh < m) scrh = '1;
         end else begin
            scrh = (m >= 64'(llo)) ? 64'd0 : 64'(llo) - m;
         end
         r.below_floor = r.temperature < floor_temp;
         if (!r.below_floor) begin
            a = cool_scale;
            rv = rho;
            sv = scrh;
            prodv = a * rv * rv * sv;
            if (prodv[159:127] != 0) r.cooling_rate = 64'h8000_0000_0000_0000;
            else r.cooling_rate = -prodv[127:64];
         end
         pending_results.push_back(r);
      endfunction

      function void check_result(bit [RspDataW-1:0] d);
         cooling_result_t e;
         if (pending_results.size() == 0) begin
            $error("result with nothing pending: %h", d);
            mismatches++;
            return;
         end
         e = pending_results.pop_front();
         if (d[31:0] != e.temperature) begin
            $error("temperature exp %h got %h", e.temperature, d[31:0]);
            mismatches++;
         end
         if (d[95:32] != e.cooling_rate) begin
            $error("cooling_rate exp %h got %h", e.cooling_rate, d[95:32]);
            mismatches++;
         end
         if (d[96] != e.below_floor) begin
            $error("below_floor exp %b got %b", e.below_floor, d[96]);
            mismatches++;
         end
         if (d[97] != e.density_zero) begin
            $error("density_zero exp %b got %b", e.density_zero, d[97]);
            mismatches++;
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata;
   logic                req_tuser;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RspDataW-1:0] rsp_tdata;
   logic                csr_we;
   logic [CsrIdxW-1:0]  csr_index;
   logic [CsrDataW-1:0] csr_wdata;

   cooling_scoreboard sb = new();
   bit  gaps_on = 0;
   bit  hold_rsp = 0;
   int  quiet_cycles = 0;
   localparam int QuietLimit = 20000;
   localparam int LoadedEntries = 512;

   cooling_table_interpolator_unit dut (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QuietLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // result side
   initial begin
      int stall;
      rsp_tready = 0;
      @(negedge reset);
      forever begin
         stall = gaps_on ? $urandom_range(0, 6) : 0;
         if (hold_rsp) begin
            hold_rsp = 0;
            stall = 400;
         end
         if (stall > 0) begin
            rsp_tready <= 0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         sb.check_result(rsp_tdata);
      end
   end

   task automatic send(bit mode, bit [ReqDataW-1:0] d);
      int gap;
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= mode;
      req_tdata <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(mode, d);
   endtask

   task automatic send_load(bit [11:0] idx, bit [31:0] t, bit [31:0] r);
      send(MODE_LOAD, {4'b0, 32'($urandom), 32'($urandom), r, t, idx});
   endtask

   task automatic send_cell(bit [31:0] p, bit [31:0] rho);
      send(MODE_CELL, {4'b0, rho, p, 32'($urandom), 32'($urandom), 12'($urandom)});
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_csr(bit [CsrIdxW-1:0] idx, bit [CsrDataW-1:0] val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      sb.write_reg(idx, val);
   endtask

   task automatic configure(bit [12:0] cnt, bit [47:0] ts, bit [31:0] cs, bit [31:0] fl);
      write_csr(CSR_TABLE_COUNT, 48'(cnt));
      write_csr(CSR_TEMP_SCALE, ts);
      write_csr(CSR_COOL_SCALE, 48'(cs));
      write_csr(CSR_FLOOR_TEMP, 48'(fl));
      @(posedge clock);
   endtask

   // cell whose temperature lands near t when the scale is one
   task automatic send_targeted(bit [31:0] t);
      bit [31:0] rho;
      bit [63:0] p;
      rho = $urandom_range(1, 65535);
      p = 64'(t) * 64'(rho) + $urandom_range(0, rho - 1);
      if (p > 64'hFFFF_FFFF) begin
         rho = 1;
         p = t;
      end
      send_cell(p[31:0], rho);
   endtask

   initial begin
      bit [31:0] t;
      int        sel;
      bit [12:0] counts[6]  = '{13'd0, 13'd1, 13'd2, 13'd4096, 13'd8191, 13'd37};
      bit [47:0] tscales[4] = '{48'd65536, 48'd0, 48'hFFFF_FFFF_FFFF, 48'd65536};
      bit [31:0] cscales[4] = '{32'd1 << 12, 32'd0, 32'hFFFF_FFFF, 32'd1};
      bit [31:0] floors[4]  = '{32'd0, 32'd10000, 32'hFFFF_FFFF, 32'd0};

      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      req_tuser = MODE_LOAD;
      csr_we = 0;
      csr_index = CSR_TABLE_COUNT;
      csr_wdata = '0;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      configure(13'd4096, 48'd65536, 32'd1 << 20, 32'd0);
      // sorted table, two equal neighbors at 5 and 6
      for (int i = 0; i < LoadedEntries; i++) begin
         t = (i == 6) ? 32'd5000 : 32'(i * 1000) + $urandom_range(0, 999);
         if (i == 5) t = 5000;
         if (i == LoadedEntries - 1) t = 32'hFFFF_FFFF;
         send_load(12'(i), t, (i % 7 == 0) ? 32'hFFFF_FFFF : 32'($urandom));
      end
      // a full-size count searches through these before reaching the loaded part
      send_load(12'd1023, 32'hFFFF_FFFF, 32'($urandom));
      send_load(12'd2047, 32'hFFFF_FFFF, 32'($urandom));
      send_cell(32'd0, 32'd0);
      send_cell(32'hFFFF_FFFF, 32'd0);
      send_cell(32'hFFFF_FFFF, 32'd1);
      send_cell(32'd0, 32'hFFFF_FFFF);
      send_cell(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_cell(32'd5000, 32'd1);
      send_cell(32'd5500, 32'd1);
      send_cell(32'd3000, 32'd1);
      send_cell(32'd123456, 32'd2);
      send_cell(32'd4000000, 32'd1);
      send_load(12'd0, 32'd100, 32'd50);
      send_load(12'd1, 32'd200, 32'd10);
      drain();
      configure(13'd2, 48'd65536, 32'hFFFF_FFFF, 32'd0);
      send_cell(32'd0, 32'd1);
      send_cell(32'd50, 32'd1);
      send_cell(32'd150, 32'd1);
      send_cell(32'd100000, 32'd1);
      send_cell(32'd1000, 32'd65536);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         configure(ph < 6 ? counts[ph] : 13'($urandom_range(2, LoadedEntries)),
                   ph < 4 ? tscales[ph] : 48'({$urandom, $urandom}),
                   ph < 4 ? cscales[ph] : $urandom >> $urandom_range(0, 31),
                   ph < 4 ? floors[ph] : $urandom_range(0, 2000000));
         gaps_on = (ph % 3 != 2);
         if (ph == 2) hold_rsp = 1;
         for (int k = 0; k < 165; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 12) begin
               send_load(12'($urandom_range(0, LoadedEntries - 2)), $urandom, $urandom);
            end else if (sel < 30) begin
               send_cell($urandom, $urandom >> $urandom_range(0, 31));
            end else begin
               send_targeted($urandom_range(0, 600000));
            end
         end
         drain();
      end

      if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
